/* rtl/core/hhw_pkg.sv */
// Shared types, command codes and flag bit positions of the host hang watchdog.
`timescale 1ns / 1ps
`default_nettype none

package hhw_pkg;

    localparam int unsigned TimerW = 16;
    localparam int unsigned FlagsW = 32;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_BUTTON   = 3'd1,
        CMD_LID      = 3'd2,
        CMD_RESUME   = 3'd3,
        CMD_SUSPEND  = 3'd4,
        CMD_SHUTDOWN = 3'd5,
        CMD_HOST     = 3'd6,
        CMD_ACTIVITY = 3'd7
    } cmd_t;

    typedef enum logic {
        CFG_EVENT_PATH_ENABLE = 1'b0,
        CFG_LID_ENABLE        = 1'b1
    } cfg_index_t;

    localparam int unsigned FL_START_POWER  = 0;
    localparam int unsigned FL_START_LIDCLS = 1;
    localparam int unsigned FL_START_LIDOPN = 2;
    localparam int unsigned FL_START_RESUME = 3;
    localparam int unsigned FL_STOP_RELEASE = 8;
    localparam int unsigned FL_STOP_HOSTCMD = 9;
    localparam int unsigned FL_STOP_SUSPEND = 10;
    localparam int unsigned FL_CLEAR_STATUS = 28;
    localparam int unsigned FL_GET_STATUS   = 29;
    localparam int unsigned FL_START_NOW    = 30;
    localparam int unsigned FL_STOP_NOW     = 31;

    typedef struct packed {
        cmd_t              cmd;
        logic              level;
        logic [FlagsW-1:0] req_flags;
        logic [TimerW-1:0] req_event_ms;
        logic [TimerW-1:0] req_reboot_ms;
    } item_t;

    typedef struct packed {
        logic status_valid;
        logic boot_status;
        logic hang_event;
        logic hang_reboot_event;
        logic reset_request;
        logic event_timer_running;
        logic reboot_timer_running;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/hhw_core.sv */
// Watchdog state, configuration registers and per-item next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module hhw_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire hhw_pkg::item_t     item,
    input  wire logic               cfg_we,
    input  wire hhw_pkg::cfg_index_t cfg_index,
    input  wire logic               cfg_data,
    output hhw_pkg::result_t        result
);

    logic                         ev_path_en_reg, ev_path_en_next;
    logic                         lid_en_reg, lid_en_next;
    logic [hhw_pkg::FlagsW-1:0]   flags_reg, flags_next;
    logic [hhw_pkg::TimerW-1:0]   ev_to_reg, ev_to_next;
    logic [hhw_pkg::TimerW-1:0]   rb_to_reg, rb_to_next;
    logic [hhw_pkg::TimerW-1:0]   ev_rem_reg, ev_rem_next;
    logic [hhw_pkg::TimerW-1:0]   rb_rem_reg, rb_rem_next;
    logic                         ev_armed_reg, ev_armed_next;
    logic                         rb_armed_reg, rb_armed_next;
    logic                         rebooted_reg, rebooted_next;

    logic ev_start, ev_stop, rb_start, rb_stop;
    logic ev_fire, rb_fire, st_valid;

    // decode which timer actions this item requests
    always_comb begin
        ev_start = 1'b0;
        ev_stop  = 1'b0;
        rb_start = 1'b0;
        rb_stop  = 1'b0;
        st_valid = 1'b0;
        ev_fire  = 1'b0;
        rb_fire  = 1'b0;
        unique case (item.cmd)
            hhw_pkg::CMD_TICK: begin
                ev_fire = ev_armed_reg && (ev_rem_reg[hhw_pkg::TimerW-1:1] == '0);
                rb_fire = rb_armed_reg && (rb_rem_reg[hhw_pkg::TimerW-1:1] == '0);
            end
            hhw_pkg::CMD_BUTTON: begin
                if (item.level) begin
                    ev_start = flags_reg[hhw_pkg::FL_START_POWER];
                end else begin
                    ev_stop = flags_reg[hhw_pkg::FL_STOP_RELEASE];
                end
            end
            hhw_pkg::CMD_LID: begin
                if (lid_en_reg) begin
                    ev_start = item.level ? flags_reg[hhw_pkg::FL_START_LIDOPN]
                                          : flags_reg[hhw_pkg::FL_START_LIDCLS];
                end
            end
            hhw_pkg::CMD_RESUME: begin
                rb_start = flags_reg[hhw_pkg::FL_START_RESUME];
            end
            hhw_pkg::CMD_SUSPEND: begin
                rb_stop = flags_reg[hhw_pkg::FL_STOP_SUSPEND];
            end
            hhw_pkg::CMD_SHUTDOWN: begin
                rb_stop = 1'b1;
            end
            hhw_pkg::CMD_HOST: begin
                if (item.req_flags[hhw_pkg::FL_GET_STATUS]) begin
                    st_valid = 1'b1;
                end else if (item.req_flags[hhw_pkg::FL_CLEAR_STATUS]) begin
                    st_valid = 1'b0;
                end else if (item.req_flags[hhw_pkg::FL_STOP_NOW]) begin
                    rb_stop = 1'b1;
                    ev_stop = 1'b1;
                end else if (item.req_flags[hhw_pkg::FL_START_NOW]) begin
                    rb_start = 1'b1;
                    ev_start = 1'b1;
                end else if (flags_reg != '0 && item.req_flags == '0) begin
                    rb_stop = 1'b1;
                    ev_stop = 1'b1;
                end
            end
            hhw_pkg::CMD_ACTIVITY: begin
                ev_stop = flags_reg[hhw_pkg::FL_STOP_HOSTCMD];
            end
        endcase
    end

    logic host_store, host_clear;
    assign host_store = (item.cmd == hhw_pkg::CMD_HOST)
                     && !item.req_flags[hhw_pkg::FL_GET_STATUS]
                     && !item.req_flags[hhw_pkg::FL_CLEAR_STATUS]
                     && !item.req_flags[hhw_pkg::FL_STOP_NOW]
                     && !item.req_flags[hhw_pkg::FL_START_NOW];
    assign host_clear = (item.cmd == hhw_pkg::CMD_HOST)
                     && !item.req_flags[hhw_pkg::FL_GET_STATUS]
                     && item.req_flags[hhw_pkg::FL_CLEAR_STATUS];

    // apply the actions to the timer state
    always_comb begin
        ev_path_en_next = ev_path_en_reg;
        lid_en_next     = lid_en_reg;
        flags_next      = flags_reg;
        ev_to_next      = ev_to_reg;
        rb_to_next      = rb_to_reg;
        ev_rem_next     = ev_rem_reg;
        rb_rem_next     = rb_rem_reg;
        ev_armed_next   = ev_armed_reg;
        rb_armed_next   = rb_armed_reg;
        rebooted_next   = rebooted_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                hhw_pkg::CFG_EVENT_PATH_ENABLE: ev_path_en_next = cfg_data;
                hhw_pkg::CFG_LID_ENABLE:        lid_en_next     = cfg_data;
            endcase
        end

        if (step) begin
            if (item.cmd == hhw_pkg::CMD_TICK) begin
                if (ev_armed_reg) begin
                    ev_rem_next = ev_rem_reg - hhw_pkg::TimerW'(1);
                end
                if (ev_fire) begin
                    ev_rem_next   = '0;
                    ev_armed_next = 1'b0;
                end
                if (rb_armed_reg) begin
                    rb_rem_next = rb_rem_reg - hhw_pkg::TimerW'(1);
                end
                if (rb_fire) begin
                    rb_rem_next   = '0;
                    rb_armed_next = 1'b0;
                    rebooted_next = 1'b1;
                end
            end
            if (rb_stop) begin
                rb_rem_next   = '0;
                rb_armed_next = 1'b0;
            end
            if (rb_start && rb_to_reg != '0) begin
                rb_rem_next   = rb_to_reg;
                rb_armed_next = 1'b1;
            end
            if (ev_stop && ev_path_en_reg) begin
                ev_rem_next   = '0;
                ev_armed_next = 1'b0;
            end
            if (ev_start && ev_path_en_reg && ev_to_reg != '0 && !ev_armed_reg) begin
                ev_rem_next   = ev_to_reg;
                ev_armed_next = 1'b1;
            end
            if (host_clear) begin
                rebooted_next = 1'b0;
            end
            if (host_store) begin
                flags_next = item.req_flags;
                ev_to_next = item.req_event_ms;
                rb_to_next = item.req_reboot_ms;
            end
            if (item.cmd == hhw_pkg::CMD_SHUTDOWN) begin
                flags_next = '0;
                ev_to_next = '0;
                rb_to_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_path_en_reg <= 1'b1;
            lid_en_reg     <= 1'b1;
            flags_reg      <= '0;
            ev_to_reg      <= '0;
            rb_to_reg      <= '0;
            ev_rem_reg     <= '0;
            rb_rem_reg     <= '0;
            ev_armed_reg   <= 1'b0;
            rb_armed_reg   <= 1'b0;
            rebooted_reg   <= 1'b0;
        end else begin
            ev_path_en_reg <= ev_path_en_next;
            lid_en_reg     <= lid_en_next;
            flags_reg      <= flags_next;
            ev_to_reg      <= ev_to_next;
            rb_to_reg      <= rb_to_next;
            ev_rem_reg     <= ev_rem_next;
            rb_rem_reg     <= rb_rem_next;
            ev_armed_reg   <= ev_armed_next;
            rb_armed_reg   <= rb_armed_next;
            rebooted_reg   <= rebooted_next;
        end
    end

    always_comb begin
        result.status_valid         = st_valid;
        result.boot_status          = rebooted_next;
        result.hang_event           = ev_fire;
        result.hang_reboot_event    = rb_fire;
        result.reset_request        = rb_fire;
        result.event_timer_running  = ev_armed_next;
        result.reboot_timer_running = rb_armed_next;
    end

`ifndef SYNTHESIS
    a_ev_armed_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_armed_reg |-> (ev_rem_reg != '0))
        else $error("event timer armed with zero remaining");

    a_rb_armed_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        rb_armed_reg |-> (rb_rem_reg != '0))
        else $error("reboot timer armed with zero remaining");

    a_rb_fire_sets_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && rb_fire) |=> rebooted_reg)
        else $error("reboot expiry did not set boot status");

    a_shutdown_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.cmd == hhw_pkg::CMD_SHUTDOWN) |=> (flags_reg == '0 && !rb_armed_reg))
        else $error("shutdown left flags or reboot timer");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> ($stable(ev_rem_reg) && $stable(rb_rem_reg) && $stable(flags_reg)))
        else $error("timer state changed without an item");
`endif

endmodule

`default_nettype wire

/* rtl/core/host_hang_watchdog.sv */
// Top level of the host hang watchdog: stream ports, input and result registers.
// An accepted item waits in the input register; when it steps, it updates the timers and its result
// is loaded into the result register and offered on m_axis.
// Throughput: one item per cycle; the input holds only while a result waits for m_axis_tready.
// Reset (aresetn low, synchronous): timers disarmed, flags, timeouts and boot status cleared,
// both enables set to 1, channels empty.
`timescale 1ns / 1ps
`default_nettype none

module host_hang_watchdog (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // level, req_flags, req_event_ms, req_reboot_ms
    input  wire logic [2:0]  s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // boot_status, hang_event, hang_reboot_event,
                                            // reset_request, event_timer_running,
                                            // reboot_timer_running
    output logic [0:0]       m_axis_tuser,  // status_valid
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);

    logic             in_valid_reg, in_valid_next;
    hhw_pkg::item_t   in_item_reg;
    logic             out_valid_reg, out_valid_next;
    hhw_pkg::result_t out_res_reg;
    hhw_pkg::result_t core_res;
    logic             advance, step, s_accept;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payloads; load the item on accept and the result on step
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.cmd           <= hhw_pkg::cmd_t'(s_axis_tuser);
            in_item_reg.level         <= s_axis_tdata[0];
            in_item_reg.req_flags     <= s_axis_tdata[32:1];
            in_item_reg.req_event_ms  <= s_axis_tdata[48:33];
            in_item_reg.req_reboot_ms <= s_axis_tdata[64:49];
        end
        if (step) begin
            out_res_reg <= core_res;
        end
    end

    hhw_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_item_reg),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (hhw_pkg::cfg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .result    (core_res)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_res_reg.status_valid;
    assign m_axis_tdata    = {2'b00,
                              out_res_reg.reboot_timer_running,
                              out_res_reg.event_timer_running,
                              out_res_reg.reset_request,
                              out_res_reg.hang_reboot_event,
                              out_res_reg.hang_event,
                              out_res_reg.boot_status};

endmodule

`default_nettype wire
